// ----- hw/rtl/gpioed_pkg.sv -----
// ----------------------------------------------------------------------------
// gpioed_pkg
// Shared types and constants for the GPIO block with edge detection.
// ----------------------------------------------------------------------------
package gpioed_pkg;

   localparam int PIN_COUNT = 28;          // pins in the block, 12 to 32
   localparam int OUT_W     = 28;          // width of the rdata and pins_out fields
   localparam int IRQ_LOW_W = 11;          // latch bits with an interrupt line each

   // request codes
   localparam logic [2:0] FUNC_DRIVE   = 3'd0;
   localparam logic [2:0] FUNC_RD_WORD = 3'd1;
   localparam logic [2:0] FUNC_WR_WORD = 3'd2;
   localparam logic [2:0] FUNC_RD_BYTE = 3'd3;
   localparam logic [2:0] FUNC_WR_BYTE = 3'd4;

   // register word index (offset bits 4:2)
   localparam logic [2:0] REG_LEVEL = 3'd0;
   localparam logic [2:0] REG_DIR   = 3'd1;
   localparam logic [2:0] REG_SET   = 3'd2;
   localparam logic [2:0] REG_CLR   = 3'd3;
   localparam logic [2:0] REG_RISE  = 3'd4;
   localparam logic [2:0] REG_FALL  = 3'd5;
   localparam logic [2:0] REG_EDGE  = 3'd6;
   localparam logic [2:0] REG_ALT   = 3'd7;

   typedef struct packed {
      logic [2:0]  func;
      logic [7:0]  offset;
      logic [4:0]  pin;
      logic        level;
      logic [31:0] wdata;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0]     rdata;
      logic [IRQ_LOW_W-1:0] irq_low;
      logic                 irq_high;
      logic [OUT_W-1:0]     pins_out;
      logic                 access_error;
   } rsp_type;

endpackage

// ----- hw/rtl/gpio_edge_detect_regs.sv -----
// ----------------------------------------------------------------------------
// gpio_edge_detect_regs
// GPIO register block: pin levels, output latch, direction, edge enables,
// edge-detect latch and alternate function, reached by pin events and
// byte or word register accesses.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------
//  req     | in  | req_valid/req_stall  | func, offset, pin, level, wdata
//  rsp     | out | rsp_valid/rsp_stall  | rdata, irqs, pins_out, error
//
// One item per cycle while no stalled result holds req_stall high; its result shows in the cycle after the transfer.
// State and result register update in the same edge as the req transfer.
// req_stall rises only while a result sits in the output register and
// rsp_stall is high. Synchronous reset clears the state registers and
// rsp_valid; the result payload register is loaded only on a transfer.
// ----------------------------------------------------------------------------
module gpio_edge_detect_regs
   import gpioed_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [PIN_COUNT-1:0] pin_levels_ff, pin_levels_in;
   logic [PIN_COUNT-1:0] out_latch_ff,  out_latch_in;
   logic [PIN_COUNT-1:0] direction_ff,  direction_in;
   logic [PIN_COUNT-1:0] rise_en_ff,    rise_en_in;
   logic [PIN_COUNT-1:0] fall_en_ff,    fall_en_in;
   logic [PIN_COUNT-1:0] edge_latch_ff, edge_latch_in;
   logic [PIN_COUNT-1:0] alt_func_ff,   alt_func_in;
   logic                 rsp_valid_ff,  rsp_valid_in;
   rsp_type              rsp_data_ff,   rsp_data_in;

   logic                 accept;
   logic [2:0]           reg_idx;
   logic [1:0]           lane;
   logic                 word_ok;
   logic                 byte_ok;
   logic [PIN_COUNT-1:0] rd_word;
   logic [31:0]          rd_word32;
   logic [31:0]          byte_merge;
   logic [31:0]          byte_mask32;
   logic [PIN_COUNT-1:0] wr_val;
   logic                 do_write;
   logic [PIN_COUNT-1:0] pin_bit;
   logic                 pin_ok;
   logic [31:0]          rdata32;
   logic                 err;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign reg_idx = req_data.offset[4:2];
   assign lane    = req_data.offset[1:0];
   // last register sits at 0x1C, so everything above bit 4 must be zero
   assign word_ok = (req_data.offset[7:5] == 3'd0) && (lane == 2'd0);
   assign byte_ok = (req_data.offset[7:5] == 3'd0);

   always_comb begin
      case (reg_idx)
         REG_LEVEL: rd_word = (out_latch_ff & direction_ff) | (pin_levels_ff & ~direction_ff);
         REG_DIR:   rd_word = direction_ff;
         REG_RISE:  rd_word = rise_en_ff;
         REG_FALL:  rd_word = fall_en_ff;
         REG_EDGE:  rd_word = edge_latch_ff;
         REG_ALT:   rd_word = alt_func_ff;
         default:   rd_word = '0;   // set and clear read as zero
      endcase
   end

   assign rd_word32   = 32'(rd_word);
   assign byte_mask32 = 32'hFF << {lane, 3'b000};
   assign byte_merge  = (rd_word32 & ~byte_mask32)
                        | ((32'(req_data.wdata[7:0])) << {lane, 3'b000});

   assign pin_ok  = ({1'b0, req_data.pin} < 6'(PIN_COUNT));
   assign pin_bit = PIN_COUNT'(1) << req_data.pin;

   always_comb begin
      pin_levels_in = pin_levels_ff;
      out_latch_in  = out_latch_ff;
      direction_in  = direction_ff;
      rise_en_in    = rise_en_ff;
      fall_en_in    = fall_en_ff;
      edge_latch_in = edge_latch_ff;
      alt_func_in   = alt_func_ff;
      rdata32       = '0;
      err           = 1'b0;
      do_write      = 1'b0;
      wr_val        = req_data.wdata[PIN_COUNT-1:0];

      case (req_data.func)
         FUNC_DRIVE: begin
            if (pin_ok) begin
               if (req_data.level) begin
                  pin_levels_in = pin_levels_ff | pin_bit;
                  // edge only when the level really changes
                  if (((pin_levels_ff & pin_bit) == '0) && ((rise_en_ff & pin_bit) != '0))
                     edge_latch_in = edge_latch_ff | pin_bit;
               end else begin
                  pin_levels_in = pin_levels_ff & ~pin_bit;
                  if (((pin_levels_ff & pin_bit) != '0) && ((fall_en_ff & pin_bit) != '0))
                     edge_latch_in = edge_latch_ff | pin_bit;
               end
            end
         end
         FUNC_RD_WORD: begin
            if (word_ok) rdata32 = rd_word32;
            else         err = 1'b1;
         end
         FUNC_WR_WORD: begin
            if (word_ok) do_write = 1'b1;
            else         err = 1'b1;
         end
         FUNC_RD_BYTE: begin
            if (byte_ok) rdata32 = (rd_word32 >> {lane, 3'b000}) & 32'hFF;
            else         err = 1'b1;
         end
         FUNC_WR_BYTE: begin
            // read-modify-write of the whole word
            if (byte_ok) begin
               do_write = 1'b1;
               wr_val   = byte_merge[PIN_COUNT-1:0];
            end else begin
               err = 1'b1;
            end
         end
         default: ;
      endcase

      if (do_write) begin
         case (reg_idx)
            REG_DIR:  direction_in  = wr_val;
            REG_SET:  out_latch_in  = out_latch_ff | (wr_val & direction_ff);
            REG_CLR:  out_latch_in  = out_latch_ff & ~(wr_val & direction_ff);
            REG_RISE: rise_en_in    = wr_val;
            REG_FALL: fall_en_in    = wr_val;
            REG_EDGE: edge_latch_in = edge_latch_ff & ~wr_val;
            REG_ALT:  alt_func_in   = wr_val;
            default:  ;   // level register is read only
         endcase
      end
   end

   always_comb begin
      rsp_data_in.rdata        = rdata32[OUT_W-1:0];
      rsp_data_in.irq_low      = edge_latch_in[IRQ_LOW_W-1:0];
      rsp_data_in.irq_high     = |edge_latch_in[PIN_COUNT-1:IRQ_LOW_W];
      rsp_data_in.pins_out     = OUT_W'(out_latch_in);
      rsp_data_in.access_error = err;
      rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pin_levels_ff <= '0;
         out_latch_ff  <= '0;
         direction_ff  <= '0;
         rise_en_ff    <= '0;
         fall_en_ff    <= '0;
         edge_latch_ff <= '0;
         alt_func_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            pin_levels_ff <= pin_levels_in;
            out_latch_ff  <= out_latch_in;
            direction_ff  <= direction_in;
            rise_en_ff    <= rise_en_in;
            fall_en_ff    <= fall_en_in;
            edge_latch_ff <= edge_latch_in;
            alt_func_ff   <= alt_func_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hw/rtl/gpioed_checker.sv -----
// ----------------------------------------------------------------------------
// gpioed_checker
// Port-level checks for the GPIO block, bound to gpio_edge_detect_regs.
// ----------------------------------------------------------------------------
module gpioed_checker
   import gpioed_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // result register empties on reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // every req transfer produces a result in the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("req transfer without result");

   // a held result blocks new requests
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("req taken while result stalled");

   // rejected access returns no read data
   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.access_error) |-> (rsp_data.rdata == '0))
      else $error("read data on rejected access");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind gpio_edge_detect_regs gpioed_checker u_gpioed_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- tb/tb_gpio_edge_detect_regs.sv -----
// ----------------------------------------------------------------------------
// tb_gpio_edge_detect_regs
// Self-checking bench for the GPIO edge-detect register block. Pin events and
// byte/word bus accesses go in through req; a shadow copy of the registers
// predicts each rsp transfer, and every field is compared in order. Both
// sides insert random gaps and stalls, and one long rsp hold fills the block.
// ----------------------------------------------------------------------------
module tb_gpio_edge_detect_regs;
   import gpioed_pkg::*;

   localparam logic [7:0] LAST_WORD_OFF = 8'h1C;
   localparam logic [7:0] LAST_BYTE_OFF = 8'h1F;
   localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
   localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
   localparam int         MAX_SHOWN     = 10;
   localparam int         HOLD_CYCLES   = 40;
   localparam int         PHASE_ITEMS   = 355;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // shadow registers
   logic [PIN_COUNT-1:0] sh_levels = '0;
   logic [PIN_COUNT-1:0] sh_out    = '0;
   logic [PIN_COUNT-1:0] sh_dir    = '0;
   logic [PIN_COUNT-1:0] sh_rise   = '0;
   logic [PIN_COUNT-1:0] sh_fall   = '0;
   logic [PIN_COUNT-1:0] sh_edge   = '0;
   logic [PIN_COUNT-1:0] sh_alt    = '0;

   rsp_type     expected_rsp_q[$];
   int          mismatch_count = 0;
   bit          req_idle_en    = 1'b1;
   bit          rsp_idle_en    = 1'b1;
   int unsigned rsp_hold_req   = 0;

   gpio_edge_detect_regs u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [7:0] word_off(input logic [2:0] idx);
      return {3'b000, idx, 2'b00};
   endfunction

   function automatic logic [PIN_COUNT-1:0] shadow_read(input logic [2:0] idx);
      case (idx)
         REG_LEVEL: return (sh_out & sh_dir) | (sh_levels & ~sh_dir);
         REG_DIR:   return sh_dir;
         REG_RISE:  return sh_rise;
         REG_FALL:  return sh_fall;
         REG_EDGE:  return sh_edge;
         REG_ALT:   return sh_alt;
         default:   return '0;   // set, clear read as zero
      endcase
   endfunction

   function automatic void shadow_write(input logic [2:0] idx, input logic [PIN_COUNT-1:0] v);
      case (idx)
         REG_DIR:  sh_dir  = v;
         REG_SET:  sh_out  = sh_out | (v & sh_dir);
         REG_CLR:  sh_out  = sh_out & ~(v & sh_dir);
         REG_RISE: sh_rise = v;
         REG_FALL: sh_fall = v;
         REG_EDGE: sh_edge = sh_edge & ~v;
         REG_ALT:  sh_alt  = v;
         default:  ;
      endcase
   endfunction

   // Applies one accepted request to the shadow registers, returns its result.
   function automatic rsp_type shadow_gpio_step(input req_type r);
      rsp_type     res;
      logic [31:0] word;
      logic [4:0]  lane_shift;
      logic [2:0]  idx;
      res        = '0;
      idx        = r.offset[4:2];
      lane_shift = {r.offset[1:0], 3'b000};
      word       = '0;
      case (r.func)
         FUNC_DRIVE: begin
            if (r.pin < PIN_COUNT) begin
               if (sh_levels[r.pin] != r.level) begin
                  sh_levels[r.pin] = r.level;
                  if (r.level ? sh_rise[r.pin] : sh_fall[r.pin])
                     sh_edge[r.pin] = 1'b1;
               end
            end
         end
         FUNC_RD_WORD, FUNC_WR_WORD: begin
            if (r.offset > LAST_WORD_OFF || r.offset[1:0] != 2'b00)
               res.access_error = 1'b1;
            else if (r.func == FUNC_RD_WORD)
               res.rdata = shadow_read(idx);
            else
               shadow_write(idx, r.wdata[PIN_COUNT-1:0]);
         end
         FUNC_RD_BYTE, FUNC_WR_BYTE: begin
            if (r.offset > LAST_BYTE_OFF) begin
               res.access_error = 1'b1;
            end else begin
               word[PIN_COUNT-1:0] = shadow_read(idx);
               if (r.func == FUNC_RD_BYTE) begin
                  word      = (word >> lane_shift) & 32'h0000_00FF;
                  res.rdata = word[OUT_W-1:0];
               end else begin
                  // read-modify-write of the whole word
                  word = (word & ~(32'h0000_00FF << lane_shift))
                       | ({24'd0, r.wdata[7:0]} << lane_shift);
                  shadow_write(idx, word[PIN_COUNT-1:0]);
               end
            end
         end
         default: ;
      endcase
      res.irq_low  = sh_edge[IRQ_LOW_W-1:0];
      res.irq_high = |sh_edge[PIN_COUNT-1:IRQ_LOW_W];
      res.pins_out = sh_out;
      return res;
   endfunction

   task automatic note_failure(input string what, input rsp_type want, input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN)
         $display("%0t %s: want rdata=%h irq_low=%h irq_high=%b pins_out=%h err=%b",
                  $realtime, what, want.rdata, want.irq_low, want.irq_high,
                  want.pins_out, want.access_error);
      if (mismatch_count <= MAX_SHOWN)
         $display("      got  rdata=%h irq_low=%h irq_high=%b pins_out=%h err=%b",
                  got.rdata, got.irq_low, got.irq_high, got.pins_out, got.access_error);
   endtask

   // Checks rsp transfers and predicts req transfers seen at the same edge.
   always @(posedge clock) begin : transfer_monitor
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               note_failure("unexpected result", '0, rsp_data);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.rdata !== want.rdata || rsp_data.irq_low !== want.irq_low ||
                   rsp_data.irq_high !== want.irq_high ||
                   rsp_data.pins_out !== want.pins_out ||
                   rsp_data.access_error !== want.access_error)
                  note_failure("result mismatch", want, rsp_data);
            end
         end
         if (req_valid && !req_stall)
            expected_rsp_q.push_back(shadow_gpio_step(req_data));
      end
   end

   // Receiver: stall for a random count before each result, or a long hold on request.
   initial begin : rsp_side
      int unsigned hold;
      rsp_stall = 1'b0;
      forever begin
         hold = rsp_idle_en ? $urandom_range(0, 4) : 0;
         if (rsp_hold_req != 0) begin
            hold         = rsp_hold_req;
            rsp_hold_req = 0;
         end
         if (hold != 0) begin
            @(negedge clock);
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall = 1'b0;
         end
         @(posedge clock);
         while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0)) @(posedge clock);
      end
   end

   task automatic issue_req(input req_type r);
      int unsigned gap;
      gap = req_idle_en ? $urandom_range(0, 4) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic bus_access(input logic [2:0] func, input logic [7:0] offset,
                             input logic [31:0] wdata);
      req_type r;
      r.func   = func;
      r.offset = offset;
      r.pin    = 5'($urandom);
      r.level  = 1'($urandom);
      r.wdata  = wdata;
      issue_req(r);
   endtask

   task automatic pin_event(input logic [4:0] pin, input logic level);
      req_type r;
      r.func   = FUNC_DRIVE;
      r.offset = 8'($urandom);
      r.pin    = pin;
      r.level  = level;
      r.wdata  = $urandom;
      issue_req(r);
   endtask

   task automatic test_output_latch();
      bus_access(FUNC_WR_WORD, word_off(REG_DIR), 32'hFFFF_FFFF);
      bus_access(FUNC_WR_WORD, word_off(REG_SET), 32'hFFFF_FFFF);
      bus_access(FUNC_WR_BYTE, word_off(REG_CLR) + 8'd1, 32'h0000_00FF);
      // byte 0 back to input: later set writes must leave it alone
      bus_access(FUNC_WR_BYTE, word_off(REG_DIR), 32'hFFFF_FF00);
      bus_access(FUNC_WR_WORD, word_off(REG_SET), 32'hFFFF_FFFF);
      bus_access(FUNC_WR_WORD, word_off(REG_LEVEL), 32'h0000_0000);
      bus_access(FUNC_RD_WORD, word_off(REG_LEVEL), 32'hFFFF_FFFF);
   endtask

   task automatic test_edge_detect();
      bus_access(FUNC_WR_WORD, word_off(REG_RISE), 32'hFFFF_FFFF);
      bus_access(FUNC_WR_BYTE, word_off(REG_FALL) + 8'd3, 32'h0000_00FF);
      pin_event(5'd0, 1'b1);
      pin_event(5'd0, 1'b1);   // same level, no edge
      pin_event(5'd27, 1'b1);
      pin_event(5'd27, 1'b0);
      pin_event(5'd28, 1'b1);  // beyond the last pin
      bus_access(FUNC_RD_BYTE, word_off(REG_EDGE) + 8'd3, 32'h0000_0000);
      // writing zeros to one lane still clears the other lanes
      bus_access(FUNC_WR_BYTE, word_off(REG_EDGE) + 8'd1, 32'h0000_0000);
      bus_access(FUNC_WR_WORD, word_off(REG_ALT), 32'hFFFF_FFFF);
      bus_access(FUNC_RD_BYTE, LAST_BYTE_OFF, 32'h0000_0000);
      bus_access(FUNC_RD_WORD, word_off(REG_SET), 32'h0000_0000);
   endtask

   task automatic test_bad_access();
      bus_access(FUNC_RD_WORD, LAST_WORD_OFF + 8'd4, 32'h0000_0000);
      bus_access(FUNC_WR_WORD, word_off(REG_DIR) + 8'd2, 32'hFFFF_FFFF);
      bus_access(FUNC_WR_BYTE, 8'hFF, 32'hFFFF_FFFF);
      bus_access(FUNC_SPARE_LO, word_off(REG_DIR), 32'hFFFF_FFFF);
      bus_access(FUNC_SPARE_HI, word_off(REG_EDGE), 32'hFFFF_FFFF);
   endtask

   task automatic test_backpressure();
      req_idle_en  = 1'b0;
      rsp_hold_req = HOLD_CYCLES;
      for (int n = 0; n < 12; n++)
         pin_event(5'($urandom_range(0, 27)), 1'($urandom));
      req_idle_en = 1'b1;
   endtask

   task automatic test_random_mix();
      req_type     r;
      int unsigned kind;
      logic [2:0]  idx;
      bit          is_byte;
      bit          is_write;
      for (int phase = 0; phase < 4; phase++) begin
         req_idle_en = (phase == 0) || (phase == 2);
         rsp_idle_en = (phase == 0) || (phase == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r.func   = 3'($urandom);
            r.offset = 8'($urandom);
            r.pin    = 5'($urandom);
            r.level  = 1'($urandom);
            r.wdata  = $urandom;
            kind     = $urandom_range(0, 99);
            if (kind < 40) begin
               r.func = FUNC_DRIVE;
               r.pin  = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(28, 31))
                                                     : 5'($urandom_range(0, 27));
            end else if (kind < 80) begin
               idx      = 3'($urandom);
               is_byte  = 1'($urandom);
               is_write = 1'($urandom);
               if (is_byte) begin
                  r.func   = is_write ? FUNC_WR_BYTE : FUNC_RD_BYTE;
                  r.offset = word_off(idx) + 8'($urandom_range(0, 3));
               end else begin
                  r.func   = is_write ? FUNC_WR_WORD : FUNC_RD_WORD;
                  r.offset = word_off(idx);
               end
               // sparse clears so the latch keeps some bits set
               if (idx == REG_EDGE)
                  r.wdata = $urandom & $urandom & $urandom;
            end else if (kind < 90) begin
               r.func = 3'($urandom_range(FUNC_RD_WORD, FUNC_WR_BYTE));
            end
            issue_req(r);
         end
      end
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
   endtask

   initial begin : run_tests
      int guard;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_output_latch();
      test_edge_detect();
      test_bad_access();
      test_backpressure();
      test_random_mix();

      @(negedge clock);
      req_valid = 1'b0;
      guard     = 0;
      while (expected_rsp_q.size() != 0 && guard < 2000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
      while (expected_rsp_q.size() != 0)
         note_failure("missing result", expected_rsp_q.pop_front(), '0);

      if (mismatch_count == 0)
         $display("tb_gpio_edge_detect_regs: clean");
      else
         $display("tb_gpio_edge_detect_regs: errors");
      $finish;
   end

   initial begin : watchdog
      #400000;
      $display("tb_gpio_edge_detect_regs: errors");
      $finish;
   end

endmodule
